### rtl/tkpc_pkg.sv
// Shared types, widths and register codes of the two-key press classifier.
`default_nettype none

package tkpc_pkg;

    localparam int TIME_WIDTH = 16;
    localparam int TICK_W     = 10;
    localparam int LIMIT_W    = 16;
    localparam int CFG_ADDR_W = 8;
    localparam int CFG_DATA_W = 16;
    localparam int IN_DATA_W  = 8;
    localparam int OUT_DATA_W = 8;

    // headroom for the saturating add and the limit compares
    localparam int SUM_W = ((TIME_WIDTH > TICK_W) ? TIME_WIDTH : TICK_W) + 1;
    localparam int CMP_W = (TIME_WIDTH > LIMIT_W) ? TIME_WIDTH : LIMIT_W;

    localparam logic [TIME_WIDTH-1:0] TIME_MAX = {TIME_WIDTH{1'b1}};

    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_TICK_PERIOD = 8'd0,
        REG_SHORT_MIN   = 8'd1,
        REG_LONG_MIN    = 8'd2,
        REG_LONG_MAX    = 8'd3
    } reg_index_t;

    typedef struct packed {
        logic [TICK_W-1:0]  tick_period_ms;
        logic [LIMIT_W-1:0] short_min_ms;
        logic [LIMIT_W-1:0] long_min_ms;
        logic [LIMIT_W-1:0] long_max_ms;
    } cfg_t;

    typedef struct packed {
        logic [TIME_WIDTH-1:0] held;
        logic                  pressed;
        logic                  fired;
    } key_state_t;

    typedef struct packed {
        logic short_press;
        logic long_press;
    } key_event_t;

endpackage

`default_nettype wire

### rtl/tkpc_key.sv
// Per-key held-time update and short/long press classification for one tick.
`default_nettype none

module tkpc_key (
    input  wire logic                down,
    input  wire tkpc_pkg::cfg_t      cfg,
    input  wire tkpc_pkg::key_state_t cur,
    output tkpc_pkg::key_state_t     nxt,
    output tkpc_pkg::key_event_t     evt
);

    logic [tkpc_pkg::SUM_W-1:0]      sum;
    logic [tkpc_pkg::TIME_WIDTH-1:0] held_inc;
    tkpc_pkg::key_state_t            grown;
    tkpc_pkg::key_state_t            released;
    logic [tkpc_pkg::CMP_W-1:0]      grown_cmp;
    logic [tkpc_pkg::CMP_W-1:0]      rel_cmp;
    logic [tkpc_pkg::CMP_W-1:0]      smin;
    logic [tkpc_pkg::CMP_W-1:0]      lmin;
    logic [tkpc_pkg::CMP_W-1:0]      lmax;

    always_comb begin
        sum = tkpc_pkg::SUM_W'(cur.held) + tkpc_pkg::SUM_W'(cfg.tick_period_ms);
        if (sum > tkpc_pkg::SUM_W'(tkpc_pkg::TIME_MAX)) begin
            held_inc = tkpc_pkg::TIME_MAX;
        end else begin
            held_inc = sum[tkpc_pkg::TIME_WIDTH-1:0];
        end

        smin = tkpc_pkg::CMP_W'(cfg.short_min_ms);
        lmin = tkpc_pkg::CMP_W'(cfg.long_min_ms);
        lmax = tkpc_pkg::CMP_W'(cfg.long_max_ms);

        // grow the count while held and no long press has fired
        grown = cur;
        if (down && !cur.fired) begin
            grown.held    = held_inc;
            grown.pressed = 1'b1;
        end
        grown_cmp = tkpc_pkg::CMP_W'(grown.held);

        evt.short_press = 1'b0;
        evt.long_press  = 1'b0;
        released        = grown;
        if (grown.pressed && !down) begin
            evt.short_press = (grown_cmp > smin) && (grown_cmp < lmin);
            released.pressed = 1'b0;
            released.fired   = 1'b0;
            released.held    = '0;
        end
        rel_cmp = tkpc_pkg::CMP_W'(released.held);

        nxt = released;
        if (grown.pressed && (rel_cmp > lmin) && (rel_cmp < lmax) && !released.fired) begin
            nxt.fired       = 1'b1;
            evt.long_press  = 1'b1;
            evt.short_press = 1'b0;
        end
    end

endmodule

`default_nettype wire

### rtl/two_key_press_classifier_core.sv
// Top level of the two-key press classifier: config registers, key state, result register.
`default_nettype none

// Two-key short/long press classifier. Each item on the s_ channel is one scan tick
// carrying the two key levels and the alarm flag; each tick gives exactly one result
// item on the m_ channel with the lock and shake settings after the tick and the beep,
// flash and lock-alarm pulses. The key state and the result register are updated in
// the cycle of acceptance, and s_tready stays high while the result register is empty
// or being drained, so the throughput is one item per cycle while m_tready holds high.
// The user must write thresholds and the tick period through the cfg_ port (always
// ready) only while no item is in flight; the block itself does not enforce it.

module two_key_press_classifier_core (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    // [0] key_one_down, [1] key_two_down, [2] alarm_active, rest zero
    input  wire logic [tkpc_pkg::IN_DATA_W-1:0]    s_tdata,
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    // [0] lock_on, [1] shake_on, [2] beep_start, [3] flash_request,
    // [4] lock_alarm_request, rest zero
    output logic [tkpc_pkg::OUT_DATA_W-1:0]        m_tdata,
    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire logic [tkpc_pkg::CFG_ADDR_W-1:0]   cfg_addr,
    input  wire logic [tkpc_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

    tkpc_pkg::cfg_t       cfg_reg;
    tkpc_pkg::key_state_t key_one_reg, key_one_next, key_one_calc;
    tkpc_pkg::key_state_t key_two_reg, key_two_next, key_two_calc;
    tkpc_pkg::key_event_t evt_one, evt_two;
    logic                 lock_reg, lock_next;
    logic                 shake_reg, shake_next;
    logic                 m_tvalid_reg;
    logic [4:0]           result_reg, result_next;
    logic                 s_accept;
    logic                 d1, d2, alarm, run_one, run_two;
    logic                 beep, flash, lalarm;

    assign cfg_ready = 1'b1;
    assign s_tready  = !m_tvalid_reg || m_tready;
    assign s_accept  = s_tvalid && s_tready;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = {{(tkpc_pkg::OUT_DATA_W-5){1'b0}}, result_reg};

    assign d1    = s_tdata[0];
    assign d2    = s_tdata[1];
    assign alarm = s_tdata[2];

    tkpc_key u_key_one (
        .down (d1),
        .cfg  (cfg_reg),
        .cur  (key_one_reg),
        .nxt  (key_one_calc),
        .evt  (evt_one)
    );

    tkpc_key u_key_two (
        .down (d2),
        .cfg  (cfg_reg),
        .cur  (key_two_reg),
        .nxt  (key_two_calc),
        .evt  (evt_two)
    );

    always_comb begin
        // alarm with key one down skips the tick; with key two down skips key two
        run_one = !(d1 && alarm);
        run_two = run_one && !(d2 && alarm);

        key_one_next = key_one_reg;
        key_two_next = key_two_reg;
        lock_next    = lock_reg;
        shake_next   = shake_reg;
        beep         = 1'b0;
        flash        = 1'b0;
        lalarm       = 1'b0;

        if (run_one) begin
            key_one_next = key_one_calc;
            if (evt_one.short_press) begin
                lock_next = !lock_reg;
                beep      = 1'b1;
            end
            if (evt_one.long_press) begin
                flash = 1'b1;
            end
        end
        if (run_two) begin
            key_two_next = key_two_calc;
            if (evt_two.short_press) begin
                if (lock_next) begin
                    flash  = 1'b1;
                    lalarm = 1'b1;
                end else begin
                    shake_next = !shake_reg;
                    beep       = 1'b1;
                end
            end
            if (evt_two.long_press) begin
                flash = 1'b1;
            end
        end
        result_next = {lalarm, flash, beep, shake_next, lock_next};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.tick_period_ms <= tkpc_pkg::TICK_W'(10);
            cfg_reg.short_min_ms   <= tkpc_pkg::LIMIT_W'(50);
            cfg_reg.long_min_ms    <= tkpc_pkg::LIMIT_W'(1500);
            cfg_reg.long_max_ms    <= tkpc_pkg::LIMIT_W'(3000);
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_addr)
                tkpc_pkg::REG_TICK_PERIOD:
                    cfg_reg.tick_period_ms <= cfg_wdata[tkpc_pkg::TICK_W-1:0];
                tkpc_pkg::REG_SHORT_MIN: cfg_reg.short_min_ms <= cfg_wdata;
                tkpc_pkg::REG_LONG_MIN:  cfg_reg.long_min_ms  <= cfg_wdata;
                tkpc_pkg::REG_LONG_MAX:  cfg_reg.long_max_ms  <= cfg_wdata;
                default: begin
                    // drop writes to unknown indexes
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            key_one_reg  <= '0;
            key_two_reg  <= '0;
            lock_reg     <= 1'b0;
            shake_reg    <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (s_accept) begin
                key_one_reg  <= key_one_next;
                key_two_reg  <= key_two_next;
                lock_reg     <= lock_next;
                shake_reg    <= shake_next;
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            result_reg <= result_next;
        end
    end

    a_accept_fills: assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept |=> m_tvalid_reg)
        else $error("accepted item produced no result");

    a_lalarm_flash: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid_reg && result_reg[4] |-> result_reg[3])
        else $error("lock alarm without flash");

    a_skip_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept && d1 && alarm |=> $stable(lock_reg) && $stable(shake_reg)
            && $stable(key_one_reg) && $stable(key_two_reg))
        else $error("skipped tick changed state");

    a_fired_one: assert property (@(posedge aclk) disable iff (!aresetn)
        key_one_reg.fired |-> key_one_reg.pressed)
        else $error("key one fired while not pressed");

    a_fired_two: assert property (@(posedge aclk) disable iff (!aresetn)
        key_two_reg.fired |-> key_two_reg.pressed)
        else $error("key two fired while not pressed");

    a_result_matches: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid_reg |-> result_reg[0] == lock_reg && result_reg[1] == shake_reg)
        else $error("shown settings differ from held state");

endmodule

`default_nettype wire

### tb/press_result_checker.sv
// Checker for the two-key press classifier: tracks ticks, predicts results, compares.
`timescale 1ns / 1ps

module press_result_checker
    import tkpc_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  s_tvalid,
    input  wire logic                  s_tready,
    input  wire logic [IN_DATA_W-1:0]  s_tdata,
    input  wire logic                  m_tvalid,
    input  wire logic                  m_tready,
    input  wire logic [OUT_DATA_W-1:0] m_tdata,
    input  wire logic                  cfg_valid,
    input  wire logic                  cfg_ready,
    input  wire logic [CFG_ADDR_W-1:0] cfg_addr,
    input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
    output int                         mismatch_count,
    output int                         pending_count
);

    typedef enum logic [1:0] {
        PRESS_NONE,
        PRESS_SHORT,
        PRESS_LONG
    } press_kind_t;

    typedef struct packed {
        logic lock_on;
        logic shake_on;
        logic beep_start;
        logic flash_request;
        logic lock_alarm_request;
    } press_result_t;

    cfg_t          settings;
    key_state_t    keys [2];
    logic          lock_state;
    logic          shake_state;
    press_result_t expected_results [$];
    press_result_t oldest;
    int            results_seen;

    initial begin
        mismatch_count = 0;
        pending_count  = 0;
        results_seen   = 0;
    end

    task automatic report_mismatch(input string msg);
        $display("[%0t] result %0d: %s", $time, results_seen, msg);
        mismatch_count++;
    endtask

    // One key for one scan tick: grow the hold time, classify on release,
    // fire a long press once per hold.
    function automatic press_kind_t classify_key_tick(input int k, input logic down);
        logic [SUM_W-1:0] sum;
        press_kind_t      kind;
        kind = PRESS_NONE;
        if (down && !keys[k].fired) begin
            sum = keys[k].held + settings.tick_period_ms;
            keys[k].held    = (sum > TIME_MAX) ? TIME_MAX : sum[TIME_WIDTH-1:0];
            keys[k].pressed = 1'b1;
        end
        if (keys[k].pressed) begin
            if (!down) begin
                if (keys[k].held > settings.short_min_ms && keys[k].held < settings.long_min_ms)
                    kind = PRESS_SHORT;
                keys[k] = '0;
            end
            if (keys[k].held > settings.long_min_ms && keys[k].held < settings.long_max_ms
                    && !keys[k].fired) begin
                keys[k].fired = 1'b1;
                kind = PRESS_LONG;
            end
        end
        return kind;
    endfunction

    function automatic press_result_t predict_tick(input logic [2:0] levels);
        press_result_t res;
        press_kind_t   kind;
        logic          one_down;
        logic          two_down;
        logic          alarm;
        one_down = levels[0];
        two_down = levels[1];
        alarm    = levels[2];
        res      = '0;
        // an alarm with the lock key held freezes the whole tick
        if (!(one_down && alarm)) begin
            kind = classify_key_tick(0, one_down);
            if (kind == PRESS_SHORT) begin
                lock_state     = !lock_state;
                res.beep_start = 1'b1;
            end else if (kind == PRESS_LONG) begin
                res.flash_request = 1'b1;
            end
            if (!(two_down && alarm)) begin
                kind = classify_key_tick(1, two_down);
                if (kind == PRESS_SHORT) begin
                    if (lock_state) begin
                        res.flash_request      = 1'b1;
                        res.lock_alarm_request = 1'b1;
                    end else begin
                        shake_state    = !shake_state;
                        res.beep_start = 1'b1;
                    end
                end else if (kind == PRESS_LONG) begin
                    res.flash_request = 1'b1;
                end
            end
        end
        res.lock_on  = lock_state;
        res.shake_on = shake_state;
        return res;
    endfunction

    task automatic compare_result(input press_result_t want, input logic [OUT_DATA_W-1:0] got);
        if (got[0] !== want.lock_on)
            report_mismatch($sformatf("lock_on %b, expected %b", got[0], want.lock_on));
        if (got[1] !== want.shake_on)
            report_mismatch($sformatf("shake_on %b, expected %b", got[1], want.shake_on));
        if (got[2] !== want.beep_start)
            report_mismatch($sformatf("beep_start %b, expected %b", got[2], want.beep_start));
        if (got[3] !== want.flash_request)
            report_mismatch($sformatf("flash_request %b, expected %b",
                                      got[3], want.flash_request));
        if (got[4] !== want.lock_alarm_request)
            report_mismatch($sformatf("lock_alarm_request %b, expected %b",
                                      got[4], want.lock_alarm_request));
        if (got[OUT_DATA_W-1:5] !== '0)
            report_mismatch($sformatf("padding bits %b, expected zero", got[OUT_DATA_W-1:5]));
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            settings.tick_period_ms = 10;
            settings.short_min_ms   = 50;
            settings.long_min_ms    = 1500;
            settings.long_max_ms    = 3000;
            keys[0]     = '0;
            keys[1]     = '0;
            lock_state  = 1'b0;
            shake_state = 1'b0;
            expected_results.delete();
            pending_count <= 0;
        end else begin
            // retire the result first so a tick taken in the same cycle queues behind it
            if (m_tvalid && m_tready) begin
                if (expected_results.size() == 0) begin
                    report_mismatch($sformatf("result %h with no tick waiting", m_tdata));
                end else begin
                    oldest = expected_results.pop_front();
                    compare_result(oldest, m_tdata);
                end
                results_seen++;
            end
            if (cfg_valid && cfg_ready) begin
                case (cfg_addr)
                    REG_TICK_PERIOD: settings.tick_period_ms = cfg_wdata[TICK_W-1:0];
                    REG_SHORT_MIN:   settings.short_min_ms   = cfg_wdata;
                    REG_LONG_MIN:    settings.long_min_ms    = cfg_wdata;
                    REG_LONG_MAX:    settings.long_max_ms    = cfg_wdata;
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready)
                expected_results.push_back(predict_tick(s_tdata[2:0]));
            pending_count <= expected_results.size();
        end
    end

endmodule

### tb/tb_top.sv
// Testbench top for the two-key press classifier: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module tb_top;
    import tkpc_pkg::*;

    localparam int                    WATCHDOG_LIMIT = 1000;
    localparam int                    HOLD_OFF_CYCLES = 80;
    localparam logic [CFG_ADDR_W-1:0] REG_UNMAPPED = 8'hA5;

    logic                  aclk;
    logic                  aresetn;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_ADDR_W-1:0] cfg_addr;
    logic [CFG_DATA_W-1:0] cfg_wdata;

    int   mismatches;
    int   results_pending;
    int   ticks_sent;
    int   idle_cycles;
    logic no_gaps;
    logic hold_off_request;
    logic any_accept;

    two_key_press_classifier_core i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    press_result_checker i_checker (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_addr       (cfg_addr),
        .cfg_wdata      (cfg_wdata),
        .mismatch_count (mismatches),
        .pending_count  (results_pending)
    );

    initial aclk = 1'b0;
    always #1 aclk = ~aclk;

    assign any_accept = (s_tvalid && s_tready) || (m_tvalid && m_tready)
                        || (cfg_valid && cfg_ready);

    always @(posedge aclk) begin
        if (!aresetn || any_accept) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles == WATCHDOG_LIMIT) begin
                $display("two_key_press_classifier_core verification failed");
                $finish;
            end
        end
    end

    // result side: random stalls per item, one long hold-off on request
    initial begin
        int stall;
        m_tready <= 1'b0;
        wait (aresetn === 1'b1);
        @(posedge aclk);
        forever begin
            if (hold_off_request) begin
                hold_off_request = 1'b0;
                stall = HOLD_OFF_CYCLES;
            end else begin
                stall = no_gaps ? 0 : $urandom_range(0, 11);
            end
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
        end
    end

    // Leaves s_tvalid high after the handshake; a gap in the next call or a drain lowers it.
    task automatic send_tick(input logic one, input logic two, input logic alarm);
        int gap;
        gap = no_gaps ? 0 : $urandom_range(0, 11);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {{(IN_DATA_W-3){1'b0}}, alarm, two, one};
        do @(posedge aclk); while (!s_tready);
        ticks_sent++;
    endtask

    task automatic tap(input logic one, input logic two, input int ticks);
        repeat (ticks) send_tick(one, two, 1'b0);
        send_tick(1'b0, 1'b0, 1'b0);
    endtask

    task automatic write_reg(input logic [CFG_ADDR_W-1:0] addr,
                             input logic [CFG_DATA_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_addr  <= addr;
        cfg_wdata <= value;
        do @(posedge aclk); while (!cfg_ready);
    endtask

    // The write to an unmapped index goes last so a bad decode cannot be hidden.
    task automatic configure(input logic [CFG_DATA_W-1:0] tick_ms,
                             input logic [CFG_DATA_W-1:0] short_min,
                             input logic [CFG_DATA_W-1:0] long_min,
                             input logic [CFG_DATA_W-1:0] long_max);
        write_reg(REG_TICK_PERIOD, tick_ms);
        write_reg(REG_SHORT_MIN, short_min);
        write_reg(REG_LONG_MIN, long_min);
        write_reg(REG_LONG_MAX, long_max);
        write_reg(REG_UNMAPPED, 16'hFFFF);
        cfg_valid <= 1'b0;
    endtask

    task automatic wait_results_drained();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (results_pending != 0) @(posedge aclk);
        repeat (2) @(posedge aclk);
    endtask

    // Mostly clean holds and releases with random length and keys; the rest
    // bounces keys, raises the alarm mid-hold or is plain noise.
    task automatic run_gestures(input int budget, input int max_hold);
        int         first;
        int         hold;
        int         kind;
        logic [1:0] held_keys;
        logic [2:0] noise;
        first = ticks_sent;
        while (ticks_sent - first < budget) begin
            no_gaps = ($urandom_range(0, 5) == 0);
            kind = $urandom_range(0, 9);
            if (kind < 2) begin
                repeat ($urandom_range(1, 4)) begin
                    noise = 3'($urandom_range(0, 7));
                    send_tick(noise[0], noise[1], noise[2]);
                end
            end else begin
                held_keys = 2'($urandom_range(1, 3));
                hold = $urandom_range(1, max_hold);
                for (int i = 0; i < hold; i++) begin
                    if (kind == 2 && $urandom_range(0, 3) == 0) begin
                        noise = 3'($urandom_range(0, 7));
                        send_tick(noise[0], noise[1], noise[2]);
                    end else begin
                        send_tick(held_keys[0], held_keys[1], $urandom_range(0, 24) == 0);
                    end
                end
                send_tick(1'b0, 1'b0, $urandom_range(0, 3) == 0);
            end
        end
        no_gaps = 1'b0;
    endtask

    initial begin
        logic [2:0] noise;
        aresetn          <= 1'b0;
        s_tvalid         <= 1'b0;
        s_tdata          <= '0;
        cfg_valid        <= 1'b0;
        cfg_addr         <= '0;
        cfg_wdata        <= '0;
        no_gaps          = 1'b0;
        hold_off_request = 1'b0;
        ticks_sent       = 0;
        idle_cycles      = 0;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // 10 ms ticks: short press at 2 ticks, long press fires at 5
        configure(10, 15, 40, 70);
        tap(1'b1, 1'b0, 2);
        tap(1'b0, 1'b1, 2);
        tap(1'b1, 1'b0, 2);
        tap(1'b0, 1'b1, 2);
        tap(1'b1, 1'b0, 5);
        send_tick(1'b1, 1'b0, 1'b1);
        send_tick(1'b0, 1'b1, 1'b1);
        tap(1'b1, 1'b1, 5);
        run_gestures(80, 9);

        // stall the result side while ticks keep coming, then pause until drained
        wait_results_drained();
        hold_off_request = 1'b1;
        no_gaps = 1'b1;
        repeat (20) begin
            noise = 3'($urandom_range(0, 7));
            send_tick(noise[0], noise[1], noise[2]);
        end
        no_gaps = 1'b0;
        wait_results_drained();

        // 1000 ms tick with a long window that never opens: the counter must saturate
        configure(1000, 0, 65534, 65535);
        tap(1'b1, 1'b0, 70);
        tap(1'b0, 1'b1, 70);
        run_gestures(40, 80);

        wait_results_drained();
        configure(1, 2, 6, 12);
        run_gestures(50, 15);

        // zero tick period: nothing is ever classified
        wait_results_drained();
        configure(0, 65535, 0, 65535);
        run_gestures(40, 5);

        wait_results_drained();
        configure(1023, 1000, 3000, 9000);
        run_gestures(50, 12);

        wait_results_drained();
        configure(100, 50, 1500, 3000);
        run_gestures(40, 35);

        wait_results_drained();
        configure(10, 0, 0, 0);
        run_gestures(30, 6);

        wait_results_drained();
        repeat (8) @(posedge aclk);
        if (mismatches == 0 && results_pending == 0) begin
            $display("two_key_press_classifier_core verification clean");
        end else begin
            $display("two_key_press_classifier_core verification failed");
        end
        $finish;
    end

endmodule
